// File: rtl/bbr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 RGB box blur.
// No dependencies; used by box_blur_rgb_3x3_unit.

package bbr_pkg;

    localparam int COL_W     = 10;
    localparam int ROW_W     = 12;
    localparam int SUM_W     = 12;
    localparam int RECIP_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Reset geometry, kept as the last column and last row of the frame
    localparam logic [COL_W-1:0] WIDTH_LAST_RESET  = 10'd1023;
    localparam logic [ROW_W-1:0] HEIGHT_LAST_RESET = 12'd767;

    // ceil(2^16 / 9); exact floor(sum / 9) for every sum of nine 8-bit values
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    // One line-store word: the column's pixel two rows up and one row up
    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } line_pair_t;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic [COL_W-1:0] out_column;
        logic [ROW_W-1:0] out_row;
        logic             frame_last;
    } pixel_out_t;

endpackage

// File: rtl/box_blur_rgb_3x3_unit.sv
`timescale 1ns / 1ps
// 3x3 box blur over an RGB raster stream, line store in one synchronous RAM.
// Depends on bbr_pkg.

// Usage
//   pixel channel : pixel_valid / pixel_stall / pixel, one RGB pixel per transfer,
//                   frames in raster order.
//   result channel: result_valid / result_stall / result, one transfer for every
//                   position where the 3x3 window lies inside the frame; the output
//                   frame is (width-2) x (height-2), its last pixel has frame_last.
//   cfg channel   : cfg_valid / cfg_ready / cfg_index / cfg_data. Index 0 sets the
//                   width from cfg_data[10:0], index 1 the height; clamp to 3..1024 and 3..4096.
//                   A write to either restarts the frame at row 0, column 0.
//                   Other indexes are ignored. cfg_ready is always high.
// Timing
//   One pixel per clock sustained while the receiver does not stall. After the transfer
//   of the pixel that completes its window, stage A holds it while the RAM read
//   returns, then window shift, channel sums, reciprocal multiply into the output
//   register, which raises result_valid. The rate is set by the single line-store RAM:
//   one read and one write-back per pixel, to different columns in any cycle.
// Reset and stall
//   Reset empties the pipeline, clears the counters and sets 1024 x 768. The RAM
//   needs no clearing pass. When the receiver stalls, the output register holds
//   and the stages behind it keep filling; pixel_stall rises once all are full.

module box_blur_rgb_3x3_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  bbr_pkg::pixel_in_t               pixel,
    output logic                             result_valid,
    input  logic                             result_stall,
    output bbr_pkg::pixel_out_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bbr_pkg::CFG_DAT_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Configuration: keep the clamped last column and last row
    // ------------------------------------------------------------------
    logic [bbr_pkg::COL_W-1:0] width_last_reg;
    logic [bbr_pkg::ROW_W-1:0] height_last_reg;
    logic [bbr_pkg::COL_W-1:0] width_last_next;
    logic [bbr_pkg::ROW_W-1:0] height_last_next;
    logic [10:0]               cfg_width;
    logic [12:0]               cfg_height;
    logic                      cfg_wr_width;
    logic                      cfg_wr_height;
    logic                      cfg_restart;

    assign cfg_ready     = 1'b1;
    assign cfg_width     = cfg_data[10:0];
    assign cfg_height    = cfg_data[12:0];
    assign cfg_wr_width  = cfg_valid && (cfg_index == bbr_pkg::REG_IMAGE_WIDTH);
    assign cfg_wr_height = cfg_valid && (cfg_index == bbr_pkg::REG_IMAGE_HEIGHT);
    assign cfg_restart   = cfg_wr_width || cfg_wr_height;

    always_comb
    begin
        logic [10:0] w_minus;
        logic [12:0] h_minus;
        w_minus = cfg_width - 11'd1;
        h_minus = cfg_height - 13'd1;
        // clamp to 3..1024, store as last column
        if (cfg_width < 11'd3)
            width_last_next = 10'd2;
        else if (cfg_width > 11'd1024)
            width_last_next = 10'd1023;
        else
            width_last_next = w_minus[9:0];
        // clamp to 3..4096, store as last row
        if (cfg_height < 13'd3)
            height_last_next = 12'd2;
        else if (cfg_height > 13'd4096)
            height_last_next = 12'd4095;
        else
            height_last_next = h_minus[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= bbr_pkg::WIDTH_LAST_RESET;
            height_last_reg <= bbr_pkg::HEIGHT_LAST_RESET;
        end
        else
        begin
            if (cfg_wr_width)
                width_last_reg <= width_last_next;
            if (cfg_wr_height)
                height_last_reg <= height_last_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage advances when the one ahead frees up
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic out_valid_reg;
    logic d_ready;
    logic c_ready;
    logic b_ready;
    logic a_ready;
    logic accept;
    logic a_move;
    logic b_move;

    assign d_ready     = !out_valid_reg || !result_stall;
    assign c_ready     = !c_valid_reg || d_ready;
    assign b_ready     = !b_valid_reg || c_ready;
    assign a_ready     = !a_valid_reg || b_ready;
    assign pixel_stall = !a_ready;
    assign accept      = pixel_valid && a_ready;
    assign a_move      = a_valid_reg && b_ready;
    assign b_move      = b_valid_reg && c_ready;

    // ------------------------------------------------------------------
    // Position counters of the next input pixel
    // ------------------------------------------------------------------
    logic [bbr_pkg::COL_W-1:0] col_reg;
    logic [bbr_pkg::ROW_W-1:0] row_reg;
    logic [bbr_pkg::COL_W-1:0] col_next;
    logic [bbr_pkg::ROW_W-1:0] row_next;
    logic                      col_wrap;
    logic                      row_wrap;

    assign col_wrap = (col_reg == width_last_reg);
    assign row_wrap = (row_reg == height_last_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: hold the pixel and its position while the RAM read returns
    // ------------------------------------------------------------------
    bbr_pkg::pix_t             a_pix_reg;
    logic [bbr_pkg::COL_W-1:0] a_col_reg;
    logic [bbr_pkg::COL_W-1:0] a_out_col_reg;
    logic [bbr_pkg::ROW_W-1:0] a_out_row_reg;
    logic                      a_has_res_reg;
    logic                      a_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg     <= '{red: pixel.in_red, green: pixel.in_green, blue: pixel.in_blue};
            a_col_reg     <= col_reg;
            a_out_col_reg <= col_reg - 10'd2;
            a_out_row_reg <= row_reg - 12'd2;
            a_has_res_reg <= (col_reg >= 10'd2) && (row_reg >= 12'd2);
            a_last_reg    <= col_wrap && row_wrap;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one word per column holds both stored rows. Read at
    // transfer, write back as the pixel leaves stage A. Consecutive pixels
    // hit different columns, so a read never meets a pending write.
    // ------------------------------------------------------------------
    bbr_pkg::line_pair_t line_mem [0:1023];
    bbr_pkg::line_pair_t line_rd_reg;

    always_ff @(posedge clk)
    begin
        if (a_move)
            line_mem[a_col_reg] <= '{upper: line_rd_reg.lower, lower: a_pix_reg};
        if (accept)
            line_rd_reg <= line_mem[col_reg];
    end

    // ------------------------------------------------------------------
    // Stage B: the 3x3 window; shift left and insert the new column
    // ------------------------------------------------------------------
    bbr_pkg::pix_t             win_reg [0:2][0:2];
    logic [bbr_pkg::COL_W-1:0] b_out_col_reg;
    logic [bbr_pkg::ROW_W-1:0] b_out_row_reg;
    logic                      b_has_res_reg;
    logic                      b_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= line_rd_reg.upper;
            win_reg[1][2] <= line_rd_reg.lower;
            win_reg[2][2] <= a_pix_reg;
            b_out_col_reg <= a_out_col_reg;
            b_out_row_reg <= a_out_row_reg;
            b_has_res_reg <= a_has_res_reg;
            b_last_reg    <= a_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: channel sums; drop pixels that complete no window
    // ------------------------------------------------------------------
    logic [bbr_pkg::SUM_W-1:0] sum_red;
    logic [bbr_pkg::SUM_W-1:0] sum_green;
    logic [bbr_pkg::SUM_W-1:0] sum_blue;
    logic [bbr_pkg::SUM_W-1:0] c_sum_red_reg;
    logic [bbr_pkg::SUM_W-1:0] c_sum_green_reg;
    logic [bbr_pkg::SUM_W-1:0] c_sum_blue_reg;
    logic [bbr_pkg::COL_W-1:0] c_out_col_reg;
    logic [bbr_pkg::ROW_W-1:0] c_out_row_reg;
    logic                      c_last_reg;

    always_comb
    begin
        sum_red   = '0;
        sum_green = '0;
        sum_blue  = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum_red   = sum_red   + {4'd0, win_reg[i][j].red};
                sum_green = sum_green + {4'd0, win_reg[i][j].green};
                sum_blue  = sum_blue  + {4'd0, win_reg[i][j].blue};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (c_ready)
            c_valid_reg <= b_valid_reg && b_has_res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            c_sum_red_reg   <= sum_red;
            c_sum_green_reg <= sum_green;
            c_sum_blue_reg  <= sum_blue;
            c_out_col_reg   <= b_out_col_reg;
            c_out_row_reg   <= b_out_row_reg;
            c_last_reg      <= b_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: divide by nine through the reciprocal; output register
    // ------------------------------------------------------------------
    logic [bbr_pkg::SUM_W+bbr_pkg::RECIP_W-1:0] prod_red;
    logic [bbr_pkg::SUM_W+bbr_pkg::RECIP_W-1:0] prod_green;
    logic [bbr_pkg::SUM_W+bbr_pkg::RECIP_W-1:0] prod_blue;
    bbr_pkg::pixel_out_t                        out_reg;

    assign prod_red   = c_sum_red_reg   * bbr_pkg::RECIP_NINE;
    assign prod_green = c_sum_green_reg * bbr_pkg::RECIP_NINE;
    assign prod_blue  = c_sum_blue_reg  * bbr_pkg::RECIP_NINE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (d_ready)
            out_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_valid_reg && d_ready)
        begin
            out_reg.out_red    <= prod_red[23:16];
            out_reg.out_green  <= prod_green[23:16];
            out_reg.out_blue   <= prod_blue[23:16];
            out_reg.out_column <= c_out_col_reg;
            out_reg.out_row    <= c_out_row_reg;
            out_reg.frame_last <= c_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
